// ===== src/lshtb_pkg.sv =====
`default_nettype none

package lshtb_pkg;

  // Sizes of the vector and of the sample table set.
  localparam int unsigned DIMENSION   = 64;
  localparam int unsigned MAX_BITS    = 16;
  localparam int unsigned MAX_TABLES  = 8;
  localparam int unsigned VALUE_WIDTH = 16;

  // Fixed field widths.
  localparam int unsigned MODE_W    = 2;
  localparam int unsigned TSEL_W    = 3;
  localparam int unsigned SLOT_W    = 6;
  localparam int unsigned SAMPLE_W  = 22;
  localparam int unsigned DIVISOR_W = 16;
  localparam int unsigned HASH_W    = 16;
  localparam int unsigned TNUM_W    = 3;
  localparam int unsigned BITS_W    = 5;
  localparam int unsigned TABLES_W  = 4;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 16;

  // Derived sizes.
  localparam int unsigned COORD_AW    = $clog2(DIMENSION);
  localparam int unsigned SAMPLE_DEP  = MAX_TABLES * MAX_BITS;
  localparam int unsigned SAMPLE_AW   = $clog2(SAMPLE_DEP);
  localparam int unsigned BIT_IDX_W   = $clog2(MAX_BITS);
  localparam int unsigned TBL_IDX_W   = $clog2(MAX_TABLES);
  localparam int unsigned DIV_CNT_W   = $clog2(SAMPLE_W + 1);

  typedef logic [MODE_W-1:0]     mode_t;
  typedef logic [SAMPLE_W-1:0]   sample_t;
  typedef logic [DIVISOR_W-1:0]  divisor_t;
  typedef logic [VALUE_WIDTH-1:0] coord_t;
  typedef logic [COORD_AW-1:0]   coord_addr_t;
  typedef logic [SAMPLE_AW-1:0]  sample_addr_t;
  typedef logic [BIT_IDX_W-1:0]  bit_idx_t;
  typedef logic [TBL_IDX_W-1:0]  tbl_idx_t;
  typedef logic [TNUM_W-1:0]     tnum_t;
  typedef logic [HASH_W-1:0]     hash_t;
  typedef logic [DIV_CNT_W-1:0]  div_cnt_t;
  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;

  // Request modes.
  localparam mode_t MODE_COORD   = 2'd0;
  localparam mode_t MODE_SAMPLE  = 2'd1;
  localparam mode_t MODE_COMPUTE = 2'd2;

  // Configuration register indexes.
  localparam cfg_idx_t REG_MAX_VALUE     = 2'd0;
  localparam cfg_idx_t REG_BITS_IN_USE   = 2'd1;
  localparam cfg_idx_t REG_TABLES_IN_USE = 2'd2;

  // Result of the shared divider.
  typedef struct packed {
    sample_t  quotient;
    divisor_t remainder;
  } div_res_t;

  function automatic sample_addr_t sample_addr(tbl_idx_t t, bit_idx_t b);
    sample_addr_t base;
    base = sample_addr_t'(t) * sample_addr_t'(MAX_BITS);
    return base + sample_addr_t'(b);
  endfunction

endpackage

`default_nettype wire

// ===== src/lshtb_div.sv =====
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module lshtb_div (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire lshtb_pkg::sample_t   dividend_i,
  input  wire lshtb_pkg::divisor_t  divisor_i,
  output logic                      done_o,
  output lshtb_pkg::div_res_t       res_o
);

  lshtb_pkg::sample_t  quo_q, quo_d;
  lshtb_pkg::divisor_t rem_q, rem_d;
  lshtb_pkg::divisor_t dvs_q;
  lshtb_pkg::div_cnt_t cnt_q, cnt_d;
  logic                busy_q, busy_d;
  logic                done_q, done_d;

  logic [lshtb_pkg::DIVISOR_W:0] shifted;
  logic [lshtb_pkg::DIVISOR_W:0] diff;
  logic                          ge;

  always_comb begin
    shifted = {rem_q, quo_q[lshtb_pkg::SAMPLE_W-1]};
    ge      = shifted >= {1'b0, dvs_q};
    diff    = shifted - {1'b0, dvs_q};
  end

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      cnt_d  = lshtb_pkg::div_cnt_t'(lshtb_pkg::SAMPLE_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      quo_d = {quo_q[lshtb_pkg::SAMPLE_W-2:0], ge};
      rem_d = ge ? diff[lshtb_pkg::DIVISOR_W-1:0] : shifted[lshtb_pkg::DIVISOR_W-1:0];
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == lshtb_pkg::div_cnt_t'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i) begin
      dvs_q <= divisor_i;
    end
  end

  assign done_o          = done_q;
  assign res_o.quotient  = quo_q;
  assign res_o.remainder = rem_q;

endmodule

`default_nettype wire

// ===== src/lsh_threshold_bit_hash_index.sv =====
`default_nettype none

// Threshold bit-sampling hash. Mode 0 and mode 1 requests write a vector
// coordinate or a sample word and give no result. A compute request gives
// one result per table in use, in table order, with last set on the final
// one. Every hash bit passes through one shared 22-step restoring divider,
// and the input stays stalled while a compute request runs. A finished
// result waits in an output register, so the next request is taken even
// while the last result is still stalled. Both stores come up undefined
// and must be written before a compute request reads them.
module lsh_threshold_bit_hash_index (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  // Configuration writes.
  input  wire logic                     cfg_valid_i,
  output logic                          cfg_ready_o,
  input  wire lshtb_pkg::cfg_idx_t      cfg_index_i,
  input  wire logic [lshtb_pkg::CFG_DAT_W-1:0] cfg_data_i,
  // Requests.
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire lshtb_pkg::mode_t         in_mode_i,
  input  wire logic [lshtb_pkg::TSEL_W-1:0] in_table_sel_i,
  input  wire logic [lshtb_pkg::SLOT_W-1:0] in_slot_i,
  input  wire lshtb_pkg::sample_t       in_value_i,
  // Results.
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output lshtb_pkg::tnum_t              out_table_number_o,
  output lshtb_pkg::hash_t              out_hash_index_o,
  output logic                          out_bad_sample_o,
  output logic                          out_last_o
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SREAD  = 5'b00010,
    S_DSTART = 5'b00100,
    S_DIV    = 5'b01000,
    S_CMP    = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers.
  lshtb_pkg::divisor_t                 max_value_q;
  logic [lshtb_pkg::BITS_W-1:0]        bits_q;
  logic [lshtb_pkg::TABLES_W-1:0]      tables_q;

  // Sequencer registers.
  lshtb_pkg::tbl_idx_t t_q, t_d;
  lshtb_pkg::bit_idx_t b_q, b_d;
  lshtb_pkg::hash_t    idx_q, idx_d;
  logic                bad_q, bad_d;
  logic                emit_q, emit_d;

  // Output register.
  logic                out_valid_q, out_valid_d;
  lshtb_pkg::tnum_t    out_tnum_q;
  lshtb_pkg::hash_t    out_hash_q;
  logic                out_bad_q;
  logic                out_last_q;
  logic                out_load;

  // Stores.
  lshtb_pkg::coord_t  coord_mem [lshtb_pkg::DIMENSION];
  lshtb_pkg::sample_t sample_mem [lshtb_pkg::SAMPLE_DEP];
  lshtb_pkg::coord_t  coord_rd_q;
  lshtb_pkg::sample_t sample_rd_q;

  // Divider.
  logic                div_start;
  logic                div_done;
  lshtb_pkg::div_res_t div_res;
  lshtb_pkg::divisor_t div_eff;

  logic                in_accept;
  logic                coord_we;
  logic                sample_we;
  lshtb_pkg::bit_idx_t kb_last;
  lshtb_pkg::tbl_idx_t nt_last;
  lshtb_pkg::divisor_t thr;
  logic                past_vec;
  logic                bit_val;
  logic                last_bit;
  logic                last_tbl;
  lshtb_pkg::sample_addr_t samp_rd_addr;

  assign in_accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE) || emit_q;
  assign cfg_ready_o = 1'b1;

  assign coord_we = in_accept && (in_mode_i == lshtb_pkg::MODE_COORD) &&
                    (32'(in_slot_i) < 32'(lshtb_pkg::DIMENSION));
  assign sample_we = in_accept && (in_mode_i == lshtb_pkg::MODE_SAMPLE) &&
                     (32'(in_slot_i) < 32'(lshtb_pkg::MAX_BITS)) &&
                     (32'(in_table_sel_i) < 32'(lshtb_pkg::MAX_TABLES));

  // Out-of-range register values fold onto the nearest legal count.
  always_comb begin
    if (bits_q == '0) begin
      kb_last = '0;
    end else if (32'(bits_q) > 32'(lshtb_pkg::MAX_BITS)) begin
      kb_last = lshtb_pkg::bit_idx_t'(lshtb_pkg::MAX_BITS - 1);
    end else begin
      kb_last = lshtb_pkg::bit_idx_t'(bits_q - 1'b1);
    end
    if (tables_q == '0) begin
      nt_last = '0;
    end else if (32'(tables_q) > 32'(lshtb_pkg::MAX_TABLES)) begin
      nt_last = lshtb_pkg::tbl_idx_t'(lshtb_pkg::MAX_TABLES - 1);
    end else begin
      nt_last = lshtb_pkg::tbl_idx_t'(tables_q - 1'b1);
    end
  end

  assign div_eff  = (max_value_q == '0) ? lshtb_pkg::divisor_t'(1) : max_value_q;
  assign thr      = (div_res.remainder == '0) ? div_eff : div_res.remainder;
  assign past_vec = 32'(div_res.quotient) >= 32'(lshtb_pkg::DIMENSION);
  assign bit_val  = coord_rd_q >= lshtb_pkg::coord_t'(thr);
  assign last_bit = b_q == kb_last;
  assign last_tbl = t_q == nt_last;
  assign div_start = state_q == S_DSTART;
  assign samp_rd_addr = lshtb_pkg::sample_addr(t_q, b_q);

  lshtb_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sample_rd_q),
    .divisor_i  (div_eff),
    .done_o     (div_done),
    .res_o      (div_res)
  );

  // A finished table moves to the output register once that is free.
  assign out_load = emit_q && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    t_d     = t_q;
    b_d     = b_q;
    idx_d   = idx_q;
    bad_d   = bad_q;
    emit_d  = emit_q;
    case (state_q)
      S_IDLE: begin
        if (emit_q) begin
          if (out_load) begin
            emit_d = 1'b0;
            idx_d  = '0;
            bad_d  = 1'b0;
            b_d    = '0;
            if (!last_tbl) begin
              t_d     = t_q + 1'b1;
              state_d = S_SREAD;
            end
          end
        end else if (in_accept && (in_mode_i == lshtb_pkg::MODE_COMPUTE)) begin
          t_d     = '0;
          b_d     = '0;
          idx_d   = '0;
          bad_d   = 1'b0;
          state_d = S_SREAD;
        end
      end
      S_SREAD: begin
        state_d = S_DSTART;
      end
      S_DSTART: begin
        state_d = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          if (past_vec) begin
            bad_d = 1'b1;
            idx_d = {idx_q[lshtb_pkg::HASH_W-2:0], 1'b0};
            if (last_bit) begin
              emit_d  = 1'b1;
              state_d = S_IDLE;
            end else begin
              b_d     = b_q + 1'b1;
              state_d = S_SREAD;
            end
          end else begin
            state_d = S_CMP;
          end
        end
      end
      S_CMP: begin
        idx_d = {idx_q[lshtb_pkg::HASH_W-2:0], bit_val};
        if (last_bit) begin
          emit_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          b_d     = b_q + 1'b1;
          state_d = S_SREAD;
        end
      end
      default: begin
        state_d = S_IDLE;
        emit_d  = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      emit_q      <= 1'b0;
      out_valid_q <= 1'b0;
      max_value_q <= lshtb_pkg::divisor_t'(1);
      bits_q      <= 5'd16;
      tables_q    <= 4'd8;
      t_q         <= '0;
      b_q         <= '0;
      bad_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      emit_q      <= emit_d;
      out_valid_q <= out_valid_d;
      t_q         <= t_d;
      b_q         <= b_d;
      bad_q       <= bad_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          lshtb_pkg::REG_MAX_VALUE: begin
            max_value_q <= cfg_data_i[lshtb_pkg::DIVISOR_W-1:0];
          end
          lshtb_pkg::REG_BITS_IN_USE: begin
            bits_q <= cfg_data_i[lshtb_pkg::BITS_W-1:0];
          end
          lshtb_pkg::REG_TABLES_IN_USE: begin
            tables_q <= cfg_data_i[lshtb_pkg::TABLES_W-1:0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    if (out_load) begin
      out_tnum_q <= lshtb_pkg::tnum_t'(t_q);
      out_hash_q <= idx_q;
      out_bad_q  <= bad_q;
      out_last_q <= last_tbl;
    end
  end

  // Store write and read ports.
  always_ff @(posedge clk_i) begin
    if (coord_we) begin
      coord_mem[in_slot_i[lshtb_pkg::COORD_AW-1:0]] <=
        in_value_i[lshtb_pkg::VALUE_WIDTH-1:0];
    end
    coord_rd_q <= coord_mem[div_res.quotient[lshtb_pkg::COORD_AW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (sample_we) begin
      sample_mem[lshtb_pkg::sample_addr(in_table_sel_i[lshtb_pkg::TBL_IDX_W-1:0],
                                        in_slot_i[lshtb_pkg::BIT_IDX_W-1:0])] <= in_value_i;
    end
    sample_rd_q <= sample_mem[samp_rd_addr];
  end

  assign out_valid_o        = out_valid_q;
  assign out_table_number_o = out_tnum_q;
  assign out_hash_index_o   = out_hash_q;
  assign out_bad_sample_o   = out_bad_q;
  assign out_last_o         = out_last_q;

endmodule

`default_nettype wire

// ===== tb/lsh_hash_checker.sv =====
`default_nettype none

module lsh_hash_checker (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_valid_i,
  input  wire logic                            cfg_ready_i,
  input  wire lshtb_pkg::cfg_idx_t             cfg_index_i,
  input  wire logic [lshtb_pkg::CFG_DAT_W-1:0] cfg_data_i,
  input  wire logic                            in_valid_i,
  input  wire logic                            in_stall_i,
  input  wire lshtb_pkg::mode_t                in_mode_i,
  input  wire logic [lshtb_pkg::TSEL_W-1:0]    in_table_sel_i,
  input  wire logic [lshtb_pkg::SLOT_W-1:0]    in_slot_i,
  input  wire lshtb_pkg::sample_t              in_value_i,
  input  wire logic                            out_valid_i,
  input  wire logic                            out_stall_i,
  input  wire lshtb_pkg::tnum_t                out_table_number_i,
  input  wire lshtb_pkg::hash_t                out_hash_index_i,
  input  wire logic                            out_bad_sample_i,
  input  wire logic                            out_last_i,
  output int                                   fail_count_o,
  output int                                   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    lshtb_pkg::tnum_t table_number;
    lshtb_pkg::hash_t hash_index;
    logic             bad_sample;
    logic             last;
  } hash_result_t;

  lshtb_pkg::divisor_t              max_value_q;
  logic [lshtb_pkg::BITS_W-1:0]     bits_in_use_q;
  logic [lshtb_pkg::TABLES_W-1:0]   tables_in_use_q;
  lshtb_pkg::coord_t                coord_mem [lshtb_pkg::DIMENSION];
  lshtb_pkg::sample_t               sample_mem [lshtb_pkg::SAMPLE_DEP];
  hash_result_t                     hash_results_due [$];
  hash_result_t                     oldest;
  int                               fails;

  // One expected result per table in use, in table order.
  function automatic void predict_hash_indices();
    int unsigned  divisor, nbits, ntables, word, coord, thr, t, b;
    hash_result_t res;
    divisor = (max_value_q == '0) ? 1 : int'(max_value_q);
    if (bits_in_use_q == '0) nbits = 1;
    else if (bits_in_use_q > lshtb_pkg::MAX_BITS) nbits = lshtb_pkg::MAX_BITS;
    else nbits = bits_in_use_q;
    if (tables_in_use_q == '0) ntables = 1;
    else if (tables_in_use_q > lshtb_pkg::MAX_TABLES) ntables = lshtb_pkg::MAX_TABLES;
    else ntables = tables_in_use_q;
    for (t = 0; t < ntables; t++) begin
      res.table_number = lshtb_pkg::tnum_t'(t);
      res.hash_index   = '0;
      res.bad_sample   = 1'b0;
      for (b = 0; b < nbits; b++) begin
        word  = sample_mem[t * lshtb_pkg::MAX_BITS + b];
        coord = word / divisor;
        thr   = word % divisor;
        if (thr == 0) thr = divisor;
        // A sample past the vector leaves its bit at zero.
        if (coord >= lshtb_pkg::DIMENSION) begin
          res.bad_sample = 1'b1;
        end else if (coord_mem[coord] >= thr) begin
          res.hash_index[nbits - 1 - b] = 1'b1;
        end
      end
      res.last = (t + 1 == ntables);
      hash_results_due = {hash_results_due, res};
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_value_q     = 16'd1;
      bits_in_use_q   = 5'd16;
      tables_in_use_q = 4'd8;
      hash_results_due.delete();
      fails = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (hash_results_due.size() == 0) begin
          $error("result with no request pending: table_number %0d hash_index %h",
                 out_table_number_i, out_hash_index_i);
          fails++;
        end else begin
          oldest = hash_results_due.pop_front();
          if (out_table_number_i !== oldest.table_number) begin
            $error("table_number: expected %0d, got %0d",
                   oldest.table_number, out_table_number_i);
            fails++;
          end
          if (out_hash_index_i !== oldest.hash_index) begin
            $error("hash_index: expected %h, got %h", oldest.hash_index, out_hash_index_i);
            fails++;
          end
          if (out_bad_sample_i !== oldest.bad_sample) begin
            $error("bad_sample: expected %b, got %b", oldest.bad_sample, out_bad_sample_i);
            fails++;
          end
          if (out_last_i !== oldest.last) begin
            $error("last: expected %b, got %b", oldest.last, out_last_i);
            fails++;
          end
        end
      end

      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          lshtb_pkg::REG_MAX_VALUE:     max_value_q     = cfg_data_i;
          lshtb_pkg::REG_BITS_IN_USE:   bits_in_use_q   = cfg_data_i[lshtb_pkg::BITS_W-1:0];
          lshtb_pkg::REG_TABLES_IN_USE: tables_in_use_q = cfg_data_i[lshtb_pkg::TABLES_W-1:0];
          default: ;
        endcase
      end

      if (in_valid_i && !in_stall_i) begin
        case (in_mode_i)
          lshtb_pkg::MODE_COORD: begin
            if (in_slot_i < lshtb_pkg::DIMENSION) begin
              coord_mem[in_slot_i] = lshtb_pkg::coord_t'(in_value_i);
            end
          end
          lshtb_pkg::MODE_SAMPLE: begin
            if (in_slot_i < lshtb_pkg::MAX_BITS && in_table_sel_i < lshtb_pkg::MAX_TABLES) begin
              sample_mem[int'(in_table_sel_i) * lshtb_pkg::MAX_BITS + int'(in_slot_i)] =
                in_value_i;
            end
          end
          lshtb_pkg::MODE_COMPUTE: predict_hash_indices();
          default: ;
        endcase
      end

      fail_count_o <= fails;
      pending_o    <= hash_results_due.size();
    end
  end

endmodule

`default_nettype wire

// ===== tb/tb_lsh_threshold_bit_hash_index.sv =====
`default_nettype none

module tb_lsh_threshold_bit_hash_index;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT   = 4_000_000;
  localparam int unsigned SETTLE_CYCLES = 32;
  localparam int unsigned PHASES        = 9;
  localparam int unsigned PHASE_ITEMS   = 6;
  localparam int unsigned SAMPLE_MAX    = (1 << lshtb_pkg::SAMPLE_W) - 1;
  localparam lshtb_pkg::mode_t MODE_UNUSED = 2'd3;

  logic                            clk;
  logic                            rst_n;
  logic                            cfg_valid;
  logic                            cfg_ready;
  lshtb_pkg::cfg_idx_t             cfg_index;
  logic [lshtb_pkg::CFG_DAT_W-1:0] cfg_data;
  logic                            in_valid;
  logic                            in_stall;
  lshtb_pkg::mode_t                in_mode;
  logic [lshtb_pkg::TSEL_W-1:0]    in_table_sel;
  logic [lshtb_pkg::SLOT_W-1:0]    in_slot;
  lshtb_pkg::sample_t              in_value;
  logic                            out_valid;
  logic                            out_stall;
  lshtb_pkg::tnum_t                out_table_number;
  lshtb_pkg::hash_t                out_hash_index;
  logic                            out_bad_sample;
  logic                            out_last;
  int                              fail_count;
  int                              pending;
  int unsigned                     send_idle_pct;
  int unsigned                     recv_idle_pct;
  int unsigned                     cur_div;
  int unsigned                     cycle_count;

  lsh_threshold_bit_hash_index DUT (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .cfg_valid_i        (cfg_valid),
    .cfg_ready_o        (cfg_ready),
    .cfg_index_i        (cfg_index),
    .cfg_data_i         (cfg_data),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall),
    .in_mode_i          (in_mode),
    .in_table_sel_i     (in_table_sel),
    .in_slot_i          (in_slot),
    .in_value_i         (in_value),
    .out_valid_o        (out_valid),
    .out_stall_i        (out_stall),
    .out_table_number_o (out_table_number),
    .out_hash_index_o   (out_hash_index),
    .out_bad_sample_o   (out_bad_sample),
    .out_last_o         (out_last)
  );

  lsh_hash_checker hash_checker (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .cfg_valid_i        (cfg_valid),
    .cfg_ready_i        (cfg_ready),
    .cfg_index_i        (cfg_index),
    .cfg_data_i         (cfg_data),
    .in_valid_i         (in_valid),
    .in_stall_i         (in_stall),
    .in_mode_i          (in_mode),
    .in_table_sel_i     (in_table_sel),
    .in_slot_i          (in_slot),
    .in_value_i         (in_value),
    .out_valid_i        (out_valid),
    .out_stall_i        (out_stall),
    .out_table_number_i (out_table_number),
    .out_hash_index_i   (out_hash_index),
    .out_bad_sample_i   (out_bad_sample),
    .out_last_i         (out_last),
    .fail_count_o       (fail_count),
    .pending_o          (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  // Valid stays high after acceptance; it drops when a gap follows or when wait_for_results runs.
  task automatic send_request(lshtb_pkg::mode_t mode, logic [lshtb_pkg::TSEL_W-1:0] tsel,
                              logic [lshtb_pkg::SLOT_W-1:0] slot,
                              lshtb_pkg::sample_t value);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_mode      <= mode;
    in_table_sel <= tsel;
    in_slot      <= slot;
    in_value     <= value;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(lshtb_pkg::cfg_idx_t idx,
                                logic [lshtb_pkg::CFG_DAT_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic apply_settings(logic [lshtb_pkg::CFG_DAT_W-1:0] divisor,
                                logic [lshtb_pkg::CFG_DAT_W-1:0] bits,
                                logic [lshtb_pkg::CFG_DAT_W-1:0] tables);
    wait_for_results();
    write_register(lshtb_pkg::REG_MAX_VALUE, divisor);
    write_register(lshtb_pkg::REG_BITS_IN_USE, bits);
    write_register(lshtb_pkg::REG_TABLES_IN_USE, tables);
    cfg_valid <= 1'b0;
    cur_div = (divisor == '0) ? 1 : divisor;
    @(posedge clk);
  endtask

  // Mostly samples inside the vector under the current divisor, some past it.
  function automatic lshtb_pkg::sample_t pick_sample_word();
    int unsigned roll, coord_top, coord, word;
    roll      = $urandom_range(99);
    coord_top = SAMPLE_MAX / cur_div;
    if (roll < 8) return lshtb_pkg::sample_t'($urandom);
    if (roll < 20) coord = $urandom_range(coord_top, lshtb_pkg::DIMENSION);
    else coord = $urandom_range(lshtb_pkg::DIMENSION - 1, 0);
    word = coord * cur_div + $urandom_range(cur_div - 1, 0);
    if (word > SAMPLE_MAX) word = coord * cur_div;
    return lshtb_pkg::sample_t'(word);
  endfunction

  function automatic lshtb_pkg::sample_t pick_coordinate();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 10) return lshtb_pkg::sample_t'($urandom);
    if (roll < 20) return '0;
    return lshtb_pkg::sample_t'($urandom_range(cur_div, 0));
  endfunction

  task automatic fill_stores();
    int unsigned i;
    for (i = 0; i < lshtb_pkg::DIMENSION; i++) begin
      send_request(lshtb_pkg::MODE_COORD, 3'($urandom), 6'(i), pick_coordinate());
    end
    for (i = 0; i < lshtb_pkg::SAMPLE_DEP; i++) begin
      send_request(lshtb_pkg::MODE_SAMPLE, 3'(i / lshtb_pkg::MAX_BITS),
                   6'(i % lshtb_pkg::MAX_BITS), pick_sample_word());
    end
  endtask

  // Ignored requests are sent but do not count toward n.
  task automatic run_random_items(int unsigned n);
    int unsigned count, roll;
    count = 0;
    while (count < n) begin
      roll = $urandom_range(99);
      if (roll < 4) begin
        send_request(MODE_UNUSED, 3'($urandom), 6'($urandom),
                     lshtb_pkg::sample_t'($urandom));
      end else if (roll < 36) begin
        send_request(lshtb_pkg::MODE_COORD, 3'($urandom),
                     6'($urandom_range(lshtb_pkg::DIMENSION - 1, 0)), pick_coordinate());
        count++;
      end else if (roll < 76) begin
        if ($urandom_range(9) == 0) begin
          send_request(lshtb_pkg::MODE_SAMPLE, 3'($urandom),
                       6'($urandom_range(63, lshtb_pkg::MAX_BITS)),
                       lshtb_pkg::sample_t'($urandom));
        end else begin
          send_request(lshtb_pkg::MODE_SAMPLE, 3'($urandom_range(lshtb_pkg::MAX_TABLES - 1, 0)),
                       6'($urandom_range(lshtb_pkg::MAX_BITS - 1, 0)), pick_sample_word());
          count++;
        end
      end else begin
        send_request(lshtb_pkg::MODE_COMPUTE, 3'($urandom), 6'($urandom),
                     lshtb_pkg::sample_t'($urandom));
        count++;
      end
    end
  endtask

  initial begin
    int unsigned                     phase, roll;
    logic [lshtb_pkg::CFG_DAT_W-1:0] div_pick, bits_pick, tables_pick;

    rst_n         = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = lshtb_pkg::REG_MAX_VALUE;
    cfg_data      = '0;
    in_valid      = 1'b0;
    in_mode       = lshtb_pkg::MODE_COORD;
    in_table_sel  = '0;
    in_slot       = '0;
    in_value      = '0;
    out_stall     = 1'b0;
    send_idle_pct = 37;
    recv_idle_pct = 46;
    cur_div       = 1;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Both stores are filled before any compute request reads them.
    fill_stores();
    send_request(lshtb_pkg::MODE_COMPUTE, '0, '0, '0);

    apply_settings(16'hFFFF, 16'd16, 16'd8);
    send_request(lshtb_pkg::MODE_COORD, '0, 6'd0, '0);
    send_request(lshtb_pkg::MODE_COORD, '1, 6'd63, '1);
    send_request(lshtb_pkg::MODE_SAMPLE, 3'd0, 6'd0, '1);
    send_request(lshtb_pkg::MODE_SAMPLE, 3'd7, 6'd15, '0);
    send_request(lshtb_pkg::MODE_SAMPLE, 3'd0, 6'd1, lshtb_pkg::sample_t'(63 * 65535));
    send_request(lshtb_pkg::MODE_COMPUTE, '1, '1, '1);
    // Unused mode and a sample slot past the table change nothing.
    send_request(MODE_UNUSED, '1, '1, '1);
    send_request(lshtb_pkg::MODE_SAMPLE, 3'd0, 6'd63, '0);
    send_request(lshtb_pkg::MODE_SAMPLE, 3'd7, 6'd16, '1);
    send_request(lshtb_pkg::MODE_COMPUTE, '0, '0, '0);

    apply_settings(16'd1, 16'd1, 16'd1);
    send_request(lshtb_pkg::MODE_COMPUTE, '0, '0, '0);
    apply_settings(16'd0, 16'd0, 16'd0);
    send_request(lshtb_pkg::MODE_COMPUTE, '0, '0, '0);
    apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_request(lshtb_pkg::MODE_COMPUTE, '0, '0, '0);
    apply_settings(16'd2, 16'd17, 16'd9);
    send_request(lshtb_pkg::MODE_COMPUTE, '0, '0, '0);

    for (phase = 0; phase < PHASES; phase++) begin
      if (phase == 3) begin
        send_idle_pct <= 46;
        recv_idle_pct <= 37;
      end else if (phase == 6) begin
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
      end
      roll = $urandom_range(99);
      if (roll < 15) div_pick = 16'd1;
      else if (roll < 25) div_pick = 16'hFFFF;
      else if (roll < 60) div_pick = 16'($urandom_range(300, 2));
      else div_pick = 16'($urandom);
      if ($urandom_range(99) < 75) bits_pick = 16'($urandom_range(6, 1));
      else bits_pick = 16'($urandom);
      if ($urandom_range(99) < 75) tables_pick = 16'($urandom_range(4, 1));
      else tables_pick = 16'($urandom);
      apply_settings(div_pick, bits_pick, tables_pick);
      run_random_items(PHASE_ITEMS / 2);
      // Let the block drain completely before the second half of the phase.
      wait_for_results();
      run_random_items(PHASE_ITEMS / 2);
    end

    wait_for_results();
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
src/lshtb_pkg.sv
src/lshtb_div.sv
src/lsh_threshold_bit_hash_index.sv
tb/lsh_hash_checker.sv
tb/tb_lsh_threshold_bit_hash_index.sv
